// ===== hw/rtl/jjtg_pkg.sv =====
package jjtg_pkg;

	localparam int POS_W   = 19;
	localparam int RD_W    = 12;
	localparam int MS_W    = 2;
	localparam int FAST_W  = 17;
	localparam int WIN_W   = 12;
	localparam int CALC_W  = POS_W + 2;
	localparam int IDX_W   = 4;
	localparam int CFG_W   = POS_W;

	localparam int IN_DATA_W  = ((RD_W + MS_W + POS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((POS_W + 7) / 8) * 8;

	localparam logic [CALC_W-1:0] CRAWL_STEP = CALC_W'(200);
	localparam logic [CALC_W-1:0] BRAKE_STEP = CALC_W'(1000);

	// register indexes
	localparam logic [IDX_W-1:0] REG_REVERSE    = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_FAST_STEP  = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_HOLD_WIN   = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_UPPER      = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_FAST_LOW   = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_CRAWL_LOW  = IDX_W'(5);
	localparam logic [IDX_W-1:0] REG_DEAD_TOP   = IDX_W'(6);
	localparam logic [IDX_W-1:0] REG_FAST_HIGH  = IDX_W'(7);

	// motor status codes
	localparam logic [MS_W-1:0] MS_IN_POS = MS_W'(0);
	localparam logic [MS_W-1:0] MS_UP     = MS_W'(1);
	localparam logic [MS_W-1:0] MS_DOWN   = MS_W'(2);

	// item kinds
	localparam logic KIND_JOG  = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	// reset values
	localparam logic [FAST_W-1:0] FAST_STEP_RST  = FAST_W'(100000);
	localparam logic [WIN_W-1:0]  HOLD_WIN_RST   = WIN_W'(500);
	localparam logic [POS_W-1:0]  UPPER_RST      = POS_W'(300000);
	localparam logic [RD_W-1:0]   FAST_LOW_RST   = RD_W'(300);
	localparam logic [RD_W-1:0]   CRAWL_LOW_RST  = RD_W'(1500);
	localparam logic [RD_W-1:0]   DEAD_TOP_RST   = RD_W'(1800);
	localparam logic [RD_W-1:0]   FAST_HIGH_RST  = RD_W'(3000);

	typedef struct packed {
		logic              reverse;
		logic [FAST_W-1:0] fast_step;
		logic [WIN_W-1:0]  hold_window;
		logic [POS_W-1:0]  upper_limit;
		logic [RD_W-1:0]   fast_low;
		logic [RD_W-1:0]   crawl_low;
		logic [RD_W-1:0]   dead_top;
		logic [RD_W-1:0]   fast_high;
	} cfg_t;

endpackage

// ===== hw/rtl/joystick_jog_target_generator.sv =====
// an accepted input is registered in the input stage, then its result in the result stage
// throughput: one transaction per cycle while the output is taken; a stalled result holds the input stage
// the held target is updated with each registered result, so back-to-back samples chain correctly
// while a result waits to be taken, the input stage can still take one more transaction
// reset: arst_n clears the held target to 0 and the registers to their defaults, no items in flight
module joystick_jog_target_generator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// reading, motor_state, position, zero fill
	input  logic [jjtg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// kind
	input  logic                               s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// target, zero fill
	output logic [jjtg_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// was_clamped
	output logic                               m_axis_tuser,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [jjtg_pkg::IDX_W-1:0]         cfg_index,
	input  logic [jjtg_pkg::CFG_W-1:0]         cfg_data
);

	localparam int MS_LO  = jjtg_pkg::RD_W;
	localparam int POS_LO = jjtg_pkg::RD_W + jjtg_pkg::MS_W;

	jjtg_pkg::cfg_t                 cfg;
	logic                           valid_s1;
	logic                           kind_s1;
	logic [jjtg_pkg::RD_W-1:0]      reading_s1;
	logic [jjtg_pkg::MS_W-1:0]      motor_state_s1;
	logic [jjtg_pkg::POS_W-1:0]     position_s1;
	logic                           out_valid_q;
	logic [jjtg_pkg::POS_W-1:0]     target_q;
	logic                           clamped_q;
	logic [jjtg_pkg::POS_W-1:0]     held_q;
	logic [jjtg_pkg::POS_W-1:0]     next_target;
	logic                           next_clamped;
	logic                           advance;
	logic                           in_take;

	assign cfg_ready = 1'b1;

	jjtg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	jjtg_step u_step (
		.cfg         (cfg),
		.kind        (kind_s1),
		.reading     (reading_s1),
		.motor_state (motor_state_s1),
		.position    (position_s1),
		.held        (held_q),
		.target      (next_target),
		.was_clamped (next_clamped)
	);

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1        <= s_axis_tuser;
			reading_s1     <= s_axis_tdata[jjtg_pkg::RD_W-1:0];
			motor_state_s1 <= s_axis_tdata[MS_LO +: jjtg_pkg::MS_W];
			position_s1    <= s_axis_tdata[POS_LO +: jjtg_pkg::POS_W];
		end
	end

	// result stage and kept target
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			held_q      <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				held_q      <= next_target;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			target_q  <= next_target;
			clamped_q <= next_clamped;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = jjtg_pkg::OUT_DATA_W'(target_q);
	assign m_axis_tuser  = clamped_q;

endmodule

// ===== hw/rtl/jjtg_cfg.sv =====
module jjtg_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [jjtg_pkg::IDX_W-1:0]    cfg_index,
	input  logic [jjtg_pkg::CFG_W-1:0]    cfg_data,
	output jjtg_pkg::cfg_t                cfg
);

	jjtg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reverse     <= 1'b0;
			cfg_q.fast_step   <= jjtg_pkg::FAST_STEP_RST;
			cfg_q.hold_window <= jjtg_pkg::HOLD_WIN_RST;
			cfg_q.upper_limit <= jjtg_pkg::UPPER_RST;
			cfg_q.fast_low    <= jjtg_pkg::FAST_LOW_RST;
			cfg_q.crawl_low   <= jjtg_pkg::CRAWL_LOW_RST;
			cfg_q.dead_top    <= jjtg_pkg::DEAD_TOP_RST;
			cfg_q.fast_high   <= jjtg_pkg::FAST_HIGH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				jjtg_pkg::REG_REVERSE: begin
					cfg_q.reverse <= cfg_data[0];
				end
				jjtg_pkg::REG_FAST_STEP: begin
					cfg_q.fast_step <= cfg_data[jjtg_pkg::FAST_W-1:0];
				end
				jjtg_pkg::REG_HOLD_WIN: begin
					cfg_q.hold_window <= cfg_data[jjtg_pkg::WIN_W-1:0];
				end
				jjtg_pkg::REG_UPPER: begin
					cfg_q.upper_limit <= cfg_data[jjtg_pkg::POS_W-1:0];
				end
				jjtg_pkg::REG_FAST_LOW: begin
					cfg_q.fast_low <= cfg_data[jjtg_pkg::RD_W-1:0];
				end
				jjtg_pkg::REG_CRAWL_LOW: begin
					cfg_q.crawl_low <= cfg_data[jjtg_pkg::RD_W-1:0];
				end
				jjtg_pkg::REG_DEAD_TOP: begin
					cfg_q.dead_top <= cfg_data[jjtg_pkg::RD_W-1:0];
				end
				jjtg_pkg::REG_FAST_HIGH: begin
					cfg_q.fast_high <= cfg_data[jjtg_pkg::RD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/jjtg_step.sv =====
module jjtg_step (
	input  jjtg_pkg::cfg_t                cfg,
	input  logic                          kind,
	input  logic [jjtg_pkg::RD_W-1:0]     reading,
	input  logic [jjtg_pkg::MS_W-1:0]     motor_state,
	input  logic [jjtg_pkg::POS_W-1:0]    position,
	input  logic [jjtg_pkg::POS_W-1:0]    held,
	output logic [jjtg_pkg::POS_W-1:0]    target,
	output logic                          was_clamped
);

	logic signed [jjtg_pkg::CALC_W-1:0] pos_s;
	logic signed [jjtg_pkg::CALC_W-1:0] held_s;
	logic signed [jjtg_pkg::CALC_W-1:0] fs_s;
	logic signed [jjtg_pkg::CALC_W-1:0] hw_s;
	logic signed [jjtg_pkg::CALC_W-1:0] upper_s;
	logic signed [jjtg_pkg::CALC_W-1:0] pos_fs_up;
	logic signed [jjtg_pkg::CALC_W-1:0] pos_fs_dn;
	logic signed [jjtg_pkg::CALC_W-1:0] pos_cr_up;
	logic signed [jjtg_pkg::CALC_W-1:0] pos_cr_dn;
	logic signed [jjtg_pkg::CALC_W-1:0] pos_br_up;
	logic signed [jjtg_pkg::CALC_W-1:0] pos_br_dn;
	logic signed [jjtg_pkg::CALC_W-1:0] win_hi;
	logic signed [jjtg_pkg::CALC_W-1:0] win_lo;
	logic signed [jjtg_pkg::CALC_W-1:0] t;
	logic [jjtg_pkg::MS_W-1:0]          low_run;
	logic [jjtg_pkg::MS_W-1:0]          high_run;
	logic                               low_ok;
	logic                               high_ok;
	logic                               fast_hi_band;

	assign pos_s   = signed'({2'b00, position});
	assign held_s  = signed'({2'b00, held});
	assign fs_s    = signed'(jjtg_pkg::CALC_W'(cfg.fast_step));
	assign hw_s    = signed'(jjtg_pkg::CALC_W'(cfg.hold_window));
	assign upper_s = signed'({2'b00, cfg.upper_limit});

	assign pos_fs_up = pos_s + fs_s;
	assign pos_fs_dn = pos_s - fs_s;
	assign pos_cr_up = pos_s + signed'(jjtg_pkg::CRAWL_STEP);
	assign pos_cr_dn = pos_s - signed'(jjtg_pkg::CRAWL_STEP);
	assign pos_br_up = pos_s + signed'(jjtg_pkg::BRAKE_STEP);
	assign pos_br_dn = pos_s - signed'(jjtg_pkg::BRAKE_STEP);
	assign win_hi    = pos_s + hw_s;
	assign win_lo    = pos_s - hw_s;

	// reverse swaps which run direction serves the low side
	assign low_run      = cfg.reverse ? jjtg_pkg::MS_UP : jjtg_pkg::MS_DOWN;
	assign high_run     = cfg.reverse ? jjtg_pkg::MS_DOWN : jjtg_pkg::MS_UP;
	assign low_ok       = (motor_state == jjtg_pkg::MS_IN_POS) || (motor_state == low_run);
	assign high_ok      = (motor_state == jjtg_pkg::MS_IN_POS) || (motor_state == high_run);
	assign fast_hi_band = reading >= cfg.fast_high;

	always_comb begin
		t = held_s;
		priority if (reading < cfg.fast_low && low_ok) begin
			t = cfg.reverse ? pos_fs_up : pos_fs_dn;
		end else if (reading < cfg.crawl_low && low_ok) begin
			t = cfg.reverse ? pos_cr_up : pos_cr_dn;
		end else if (reading < cfg.dead_top) begin
			if (held_s > win_hi) begin
				t = win_hi;
			end else if (held_s < win_lo) begin
				t = win_lo;
			end else begin
				t = held_s;
			end
		end else if (!fast_hi_band && high_ok) begin
			t = cfg.reverse ? pos_cr_dn : pos_cr_up;
		end else if (fast_hi_band && motor_state == low_run) begin
			// brake against the running motor
			t = cfg.reverse ? pos_br_up : pos_br_dn;
		end else if (fast_hi_band && high_ok) begin
			t = cfg.reverse ? pos_fs_dn : pos_fs_up;
		end else begin
			t = held_s;
		end
	end

	always_comb begin
		target      = t[jjtg_pkg::POS_W-1:0];
		was_clamped = 1'b0;
		if (kind == jjtg_pkg::KIND_LOAD) begin
			target = position;
		end else if (t < 0) begin
			target      = '0;
			was_clamped = 1'b1;
		end else if (t > upper_s) begin
			target      = cfg.upper_limit;
			was_clamped = 1'b1;
		end
	end

endmodule

// ===== dv/tb_joystick_jog_target_generator.sv =====
`timescale 1ns / 1ps

module tb_joystick_jog_target_generator;
	import jjtg_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int NUM_REGS = int'(REG_FAST_HIGH) + 1;
	localparam logic [MS_W-1:0] MS_OTHER = MS_W'(3);
	localparam logic [POS_W-1:0] POS_MAX = '1;

	typedef struct {
		logic [POS_W-1:0] target;
		logic             clamped;
	} jog_result_t;

	class jog_scoreboard;
		cfg_t             regs;
		logic [POS_W-1:0] held;
		jog_result_t      expected_q[$];
		int               errors;

		function new();
			regs = '{reverse: 1'b0, fast_step: FAST_STEP_RST, hold_window: HOLD_WIN_RST,
				upper_limit: UPPER_RST, fast_low: FAST_LOW_RST, crawl_low: CRAWL_LOW_RST,
				dead_top: DEAD_TOP_RST, fast_high: FAST_HIGH_RST};
			held = '0;
			errors = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_REVERSE: regs.reverse = val[0];
				REG_FAST_STEP: regs.fast_step = val[FAST_W-1:0];
				REG_HOLD_WIN: regs.hold_window = val[WIN_W-1:0];
				REG_UPPER: regs.upper_limit = val[POS_W-1:0];
				REG_FAST_LOW: regs.fast_low = val[RD_W-1:0];
				REG_CRAWL_LOW: regs.crawl_low = val[RD_W-1:0];
				REG_DEAD_TOP: regs.dead_top = val[RD_W-1:0];
				REG_FAST_HIGH: regs.fast_high = val[RD_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic kind, logic [RD_W-1:0] rd, logic [MS_W-1:0] ms,
				logic [POS_W-1:0] pos);
			jog_result_t r;
			longint p, t, h, hw, fs, sgn, crawl, brake, lim;
			logic [MS_W-1:0] toward_low, toward_high;
			logic low_ok, high_ok;
			p = longint'(pos);
			h = longint'(held);
			t = h;
			hw = longint'(regs.hold_window);
			fs = longint'(regs.fast_step);
			lim = longint'(regs.upper_limit);
			crawl = longint'(CRAWL_STEP);
			brake = longint'(BRAKE_STEP);
			sgn = regs.reverse ? 1 : -1;
			toward_low = regs.reverse ? MS_UP : MS_DOWN;
			toward_high = regs.reverse ? MS_DOWN : MS_UP;
			low_ok = (ms == MS_IN_POS) || (ms == toward_low);
			high_ok = (ms == MS_IN_POS) || (ms == toward_high);
			r.clamped = 1'b0;
			if (kind == KIND_LOAD) begin
				held = pos;
			end else begin
				if (rd < regs.fast_low && low_ok) begin
					t = p + sgn * fs;
				end else if (rd < regs.crawl_low && low_ok) begin
					t = p + sgn * crawl;
				end else if (rd < regs.dead_top) begin
					if (h > p + hw)
						t = p + hw;
					else if (h < p - hw)
						t = p - hw;
				end else if (rd < regs.fast_high && high_ok) begin
					t = p - sgn * crawl;
				end else if (rd >= regs.fast_high && ms == toward_low) begin
					t = p + sgn * brake;
				end else if (rd >= regs.fast_high && high_ok) begin
					t = p - sgn * fs;
				end
				if (t < 0) begin
					t = 0;
					r.clamped = 1'b1;
				end else if (t > lim) begin
					t = lim;
					r.clamped = 1'b1;
				end
				held = t[POS_W-1:0];
			end
			r.target = held;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [POS_W-1:0] tgt, logic clamped);
			jog_result_t r;
			if (expected_q.size() == 0) begin
				$error("target: no transaction expected, actual %0d", tgt);
				errors++;
				return;
			end
			r = expected_q.pop_front();
			if (tgt !== r.target) begin
				$error("target: expected %0d, actual %0d", r.target, tgt);
				errors++;
			end
			if (clamped !== r.clamped) begin
				$error("was_clamped: expected %0d, actual %0d", r.clamped, clamped);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [IDX_W-1:0]      cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;

	jog_scoreboard sb;
	int cycle_count = 0;
	int burst_left = 0;
	int rx_mode = 0;
	int rx_left = 0;

	joystick_jog_target_generator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 150);
		end else begin
			rx_left = rx_left - 1;
		end
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= (rx_left % 4 == 0);
			default: m_axis_tready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata[POS_W-1:0], m_axis_tuser);
	end

	function automatic int next_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 15);
		return $urandom_range(1, 6);
	endfunction

	task automatic send(input logic kind, input logic [RD_W-1:0] rd,
			input logic [MS_W-1:0] ms, input logic [POS_W-1:0] pos);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_DATA_W'({pos, ms, rd});
		s_axis_tuser <= kind;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_sample(kind, rd, ms, pos);
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_cfg(input cfg_t c);
		drain();
		repeat (4) @(posedge clk);
		write_reg(REG_REVERSE, CFG_W'(c.reverse));
		write_reg(REG_FAST_STEP, CFG_W'(c.fast_step));
		write_reg(REG_HOLD_WIN, CFG_W'(c.hold_window));
		write_reg(REG_UPPER, CFG_W'(c.upper_limit));
		write_reg(REG_FAST_LOW, CFG_W'(c.fast_low));
		write_reg(REG_CRAWL_LOW, CFG_W'(c.crawl_low));
		write_reg(REG_DEAD_TOP, CFG_W'(c.dead_top));
		write_reg(REG_FAST_HIGH, CFG_W'(c.fast_high));
	endtask

	function automatic cfg_t random_cfg(bit ordered);
		cfg_t c;
		int a;
		c.reverse = 1'($urandom_range(0, 1));
		c.fast_step = FAST_W'($urandom);
		c.hold_window = WIN_W'($urandom);
		c.upper_limit = POS_W'($urandom);
		if (ordered) begin
			a = $urandom_range(0, 800);
			c.fast_low = RD_W'(a);
			a += $urandom_range(0, 1200);
			c.crawl_low = RD_W'(a);
			a += $urandom_range(0, 800);
			c.dead_top = RD_W'(a);
			a += $urandom_range(0, 1200);
			c.fast_high = RD_W'(a);
		end else begin
			c.fast_low = RD_W'($urandom);
			c.crawl_low = RD_W'($urandom);
			c.dead_top = RD_W'($urandom);
			c.fast_high = RD_W'($urandom);
		end
		return c;
	endfunction

	task automatic rand_item();
		logic kind;
		logic [RD_W-1:0] rd;
		logic [MS_W-1:0] ms;
		logic [POS_W-1:0] pos;
		logic [RD_W-1:0] edge_rd;
		kind = ($urandom_range(0, 11) == 0) ? KIND_LOAD : KIND_JOG;
		ms = MS_W'($urandom_range(0, 3));
		case ($urandom_range(0, 5))
			0: pos = POS_W'($urandom_range(0, 1500));
			1: pos = POS_W'(sb.regs.upper_limit + $urandom_range(0, 3000) - 1500);
			2: pos = POS_MAX - POS_W'($urandom_range(0, 1500));
			default: pos = POS_W'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: edge_rd = sb.regs.fast_low;
			1: edge_rd = sb.regs.crawl_low;
			2: edge_rd = sb.regs.dead_top;
			default: edge_rd = sb.regs.fast_high;
		endcase
		if ($urandom_range(0, 3) == 0)
			rd = RD_W'(edge_rd + $urandom_range(0, 4) - 2);
		else
			rd = RD_W'($urandom);
		send(kind, rd, ms, pos);
	endtask

	task automatic run_phase(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 39) == 0)
				drain();
			rand_item();
		end
	endtask

	initial begin
		cfg_t c;
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default settings, every band and both clamps
		send(KIND_LOAD, 12'd0, MS_IN_POS, 19'd0);
		send(KIND_JOG, 12'd0, MS_IN_POS, 19'd50000);
		send(KIND_JOG, 12'd299, MS_DOWN, 19'd200000);
		send(KIND_JOG, 12'd300, MS_IN_POS, 19'd1000);
		send(KIND_JOG, 12'd1499, MS_UP, 19'd5000);
		send(KIND_JOG, 12'd1500, MS_OTHER, 19'd4000);
		send(KIND_JOG, 12'd1799, MS_IN_POS, 19'd1000);
		send(KIND_JOG, 12'd1800, MS_UP, 19'd299900);
		send(KIND_JOG, 12'd2999, MS_DOWN, 19'd10);
		send(KIND_JOG, 12'd3000, MS_DOWN, 19'd600);
		send(KIND_JOG, 12'd4095, MS_IN_POS, POS_MAX);
		send(KIND_JOG, 12'd4095, MS_UP, 19'd100);
		send(KIND_JOG, 12'd4095, MS_OTHER, 19'd0);
		send(KIND_JOG, 12'd0, MS_UP, 19'd7);
		send(KIND_LOAD, 12'd4095, MS_OTHER, POS_MAX);
		send(KIND_JOG, 12'd3500, MS_OTHER, 19'd0);
		send(KIND_LOAD, 12'd1000, MS_DOWN, 19'd400000);
		send(KIND_JOG, 12'd0, MS_OTHER, 19'd400000);
		send(KIND_JOG, 12'd2047, MS_IN_POS, 19'd262144);
		send(KIND_JOG, 12'd1234, MS_DOWN, 19'd1000);

		// mirrored direction
		c = sb.regs;
		c.reverse = 1'b1;
		apply_cfg(c);
		send(KIND_JOG, 12'd0, MS_UP, 19'd1000);
		send(KIND_JOG, 12'd3000, MS_UP, 19'd500);
		send(KIND_JOG, 12'd2000, MS_DOWN, 19'd5000);
		send(KIND_JOG, 12'd4095, MS_DOWN, 19'd299000);
		send(KIND_JOG, 12'd1000, MS_DOWN, 19'd10);

		apply_cfg('{reverse: 1'b0, fast_step: '1, hold_window: '1, upper_limit: '1,
			fast_low: 12'd1000, crawl_low: 12'd2000, dead_top: 12'd2500, fast_high: 12'd3500});
		run_phase(68);

		apply_cfg('{reverse: 1'b1, fast_step: '0, hold_window: '0, upper_limit: '0,
			fast_low: '0, crawl_low: '0, dead_top: '0, fast_high: '0});
		run_phase(68);

		apply_cfg('{reverse: 1'b0, fast_step: 17'd5000, hold_window: 12'd100,
			upper_limit: 19'd1000, fast_low: '1, crawl_low: '1, dead_top: '1, fast_high: '1});
		run_phase(68);

		// thresholds out of order, plus a write to an unused index
		apply_cfg(random_cfg(1'b0));
		write_reg(IDX_W'(NUM_REGS + $urandom_range(0, 7)), CFG_W'($urandom));
		run_phase(68);

		repeat (3) begin
			apply_cfg(random_cfg(1'b1));
			run_phase(68);
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
